>>> hdl/mer_pkg.sv
package mer_pkg;

   // Defaults for the top-level parameters.
   localparam int RADIUS_BITS_DEF = 11;
   localparam int COORD_BITS_DEF  = 14;

   // Fixed widths of the configuration port.
   localparam int CENTER_BITS    = 12;
   localparam int CSR_INDEX_BITS = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_X = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS_Y = 2'd3;

   // Operand pairs of the shared multiplier.
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_A2_B,
      MUL_TT,
      MUL_YY,
      MUL_B2_TT,
      MUL_A2_Q,
      MUL_A2_B2
   } mul_sel_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_INIT_FIN,
      ST_INIT_TEST,
      ST_EMIT,
      ST_UPDATE,
      ST_E_TT,
      ST_E_YY,
      ST_E_P1,
      ST_E_P2,
      ST_E_P3,
      ST_E_FIN
   } state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic        init;
      logic        init_fin;
      logic        emit;
      logic        update;
      logic        tmp_load;
      logic        dec_load;
      logic        dec_add4;
      logic        dec_sub4;
      mul_sel_type mul_sel;
   } cmd_type;

   // Status from the datapath back to the sequencer.
   typedef struct packed {
      logic active;
      logic in_r2;
      logic slope_lt;
      logic out_free;
      logic last_pt;
   } sts_type;

endpackage

>>> hdl/mer_ctrl.sv
module mer_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_restart,
   input  mer_pkg::sts_type sts,
   output mer_pkg::cmd_type cmd
);
   import mer_pkg::*;

   state_type state_ff, state_in;
   logic      ret_emit_ff, ret_emit_in;

   // State register, plus the flag saying where the region-two entry returns to.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ret_emit_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_emit_ff <= ret_emit_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in    = state_ff;
      ret_emit_in = ret_emit_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.mul_sel = MUL_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_restart) begin
                  state_in = ST_INIT;
               end else if (sts.active) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_INIT: begin
            cmd.init    = 1'b1;
            cmd.mul_sel = MUL_A2_B;
            state_in    = ST_INIT_FIN;
         end
         ST_INIT_FIN: begin
            cmd.init_fin = 1'b1;
            state_in     = ST_INIT_TEST;
         end
         ST_INIT_TEST: begin
            if (sts.slope_lt) begin
               state_in = ST_EMIT;
            end else begin
               ret_emit_in = 1'b1;
               state_in    = ST_E_TT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (!sts.in_r2 && !sts.slope_lt) begin
               ret_emit_in = 1'b0;
               state_in    = ST_E_TT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_E_TT: begin
            cmd.mul_sel = MUL_TT;
            state_in    = ST_E_YY;
         end
         ST_E_YY: begin
            cmd.mul_sel  = MUL_YY;
            cmd.tmp_load = 1'b1;
            state_in     = ST_E_P1;
         end
         ST_E_P1: begin
            cmd.mul_sel  = MUL_B2_TT;
            cmd.tmp_load = 1'b1;
            state_in     = ST_E_P2;
         end
         ST_E_P2: begin
            cmd.mul_sel  = MUL_A2_Q;
            cmd.dec_load = 1'b1;
            state_in     = ST_E_P3;
         end
         ST_E_P3: begin
            cmd.mul_sel  = MUL_A2_B2;
            cmd.dec_add4 = 1'b1;
            state_in     = ST_E_FIN;
         end
         ST_E_FIN: begin
            cmd.dec_sub4 = 1'b1;
            state_in     = ret_emit_ff ? ST_EMIT : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/mer_datapath.sv
module mer_datapath #(
   parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
   localparam int CSR_W  = (RADIUS_BITS > mer_pkg::CENTER_BITS) ?
                           RADIUS_BITS : mer_pkg::CENTER_BITS,
   localparam int DATA_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mer_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_W-1:0]                    csr_wdata,
   input  mer_pkg::cmd_type                    cmd,
   output mer_pkg::sts_type                    sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [DATA_W-1:0]                   rsp_tdata,
   output logic                                rsp_tlast
);
   import mer_pkg::*;

   localparam int OFF_W   = RADIUS_BITS + 2;
   localparam int SLOPE_W = 3 * RADIUS_BITS + 3;
   localparam int DEC_W   = 4 * RADIUS_BITS + 4;
   localparam int SQ_W    = 2 * RADIUS_BITS;
   localparam int MUL_W   = 2 * RADIUS_BITS + 4;

   // Configuration registers and their squares.
   logic [CENTER_BITS-1:0] center_x_ff, center_y_ff;
   logic [RADIUS_BITS-1:0] radius_x_ff, radius_y_ff;
   logic [SQ_W-1:0]        a2_ff, b2_ff;

   // Walk state.
   logic signed [OFF_W-1:0]   off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic signed [SLOPE_W-1:0] slope_x_ff, slope_x_in, slope_y_ff, slope_y_in;
   logic signed [DEC_W-1:0]   dec_ff, dec_in;
   logic                      in_r2_ff, in_r2_in, active_ff, active_in;
   logic                      simple_ff, simple_in;

   // Multiplier operands, product register and scratch register.
   logic signed [MUL_W-1:0]   mul_a, mul_b, tmp_ff;
   logic signed [2*MUL_W-1:0] mul_full;
   logic signed [DEC_W-1:0]   prod_ff;
   logic signed [OFF_W:0]     t_val, ym1_val;

   // Widened copies of the squares.
   logic signed [SLOPE_W-1:0] a2_s, b2_s;
   logic signed [DEC_W-1:0]   a2_d, b2_d, sx_d, sy_d, dec_term;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]            rsp_data_ff;
   logic                         rsp_last_ff;
   logic signed [COORD_BITS-1:0] cx_c, cy_c, ox_c, oy_c;
   logic                         last_pt;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_x_ff <= '0;
         radius_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata[CENTER_BITS-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_wdata[CENTER_BITS-1:0];
            CSR_RADIUS_X: radius_x_ff <= csr_wdata[RADIUS_BITS-1:0];
            CSR_RADIUS_Y: radius_y_ff <= csr_wdata[RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Squares of the radii are registered, following the radius registers in the next cycle.
   always_ff @(posedge clock) begin
      a2_ff <= radius_x_ff * radius_x_ff;
      b2_ff <= radius_y_ff * radius_y_ff;
   end

   assign a2_s = SLOPE_W'({1'b0, a2_ff});
   assign b2_s = SLOPE_W'({1'b0, b2_ff});
   assign a2_d = DEC_W'({1'b0, a2_ff});
   assign b2_d = DEC_W'({1'b0, b2_ff});
   assign sx_d = DEC_W'(slope_x_ff);
   assign sy_d = DEC_W'(slope_y_ff);

   // Midpoint operands for the region-two start value: 2x+1 and y-1.
   assign t_val   = {off_x_ff, 1'b1};
   assign ym1_val = {off_y_ff[OFF_W-1], off_y_ff} - 1'b1;

   // Shared multiplier with a registered product.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_A2_B: begin
            mul_a = MUL_W'({1'b0, a2_ff});
            mul_b = MUL_W'({1'b0, radius_y_ff});
         end
         MUL_TT: begin
            mul_a = MUL_W'(t_val);
            mul_b = MUL_W'(t_val);
         end
         MUL_YY: begin
            mul_a = MUL_W'(ym1_val);
            mul_b = MUL_W'(ym1_val);
         end
         MUL_B2_TT: begin
            mul_a = MUL_W'({1'b0, b2_ff});
            mul_b = tmp_ff;
         end
         MUL_A2_Q: begin
            mul_a = MUL_W'({1'b0, a2_ff});
            mul_b = tmp_ff;
         end
         MUL_A2_B2: begin
            mul_a = MUL_W'({1'b0, a2_ff});
            mul_b = MUL_W'({1'b0, b2_ff});
         end
         default: ;
      endcase
   end

   assign mul_full = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= DEC_W'(mul_full);
      if (cmd.tmp_load) begin
         tmp_ff <= MUL_W'(prod_ff);
      end
   end

   // Decision increment after a step: the diagonal move uses both slopes.
   always_comb begin
      if (!simple_ff) begin
         dec_term = sx_d - sy_d;
      end else if (!in_r2_ff) begin
         dec_term = sx_d;
      end else begin
         dec_term = -sy_d;
      end
      dec_term = dec_term + (in_r2_ff ? a2_d : b2_d);
   end

   assign last_pt = in_r2_ff && (off_y_ff[OFF_W-1] || (off_y_ff == '0));

   // Next values of the walk state.
   always_comb begin
      off_x_in   = off_x_ff;
      off_y_in   = off_y_ff;
      slope_x_in = slope_x_ff;
      slope_y_in = slope_y_ff;
      dec_in     = dec_ff;
      in_r2_in   = in_r2_ff;
      active_in  = active_ff;
      simple_in  = simple_ff;
      if (cmd.init) begin
         off_x_in   = '0;
         off_y_in   = OFF_W'({1'b0, radius_y_ff});
         slope_x_in = '0;
         in_r2_in   = 1'b0;
         active_in  = 1'b1;
      end
      if (cmd.init_fin) begin
         slope_y_in = SLOPE_W'(prod_ff <<< 1);
         dec_in     = (b2_d <<< 2) - (prod_ff <<< 2) + a2_d;
      end
      if (cmd.emit) begin
         if (last_pt) begin
            active_in = 1'b0;
         end
         if (!in_r2_ff) begin
            // Region one: x always moves, y only on a non-negative decision.
            simple_in  = dec_ff[DEC_W-1];
            off_x_in   = off_x_ff + 1'b1;
            slope_x_in = slope_x_ff + (b2_s <<< 1);
            if (!dec_ff[DEC_W-1]) begin
               off_y_in   = off_y_ff - 1'b1;
               slope_y_in = slope_y_ff - (a2_s <<< 1);
            end
         end else begin
            // Region two: y always moves, x only on a non-positive decision.
            simple_in  = !dec_ff[DEC_W-1] && (dec_ff != '0);
            off_y_in   = off_y_ff - 1'b1;
            slope_y_in = slope_y_ff - (a2_s <<< 1);
            if (dec_ff[DEC_W-1] || (dec_ff == '0)) begin
               off_x_in   = off_x_ff + 1'b1;
               slope_x_in = slope_x_ff + (b2_s <<< 1);
            end
         end
      end
      if (cmd.update) begin
         dec_in = dec_ff + (dec_term <<< 2);
      end
      if (cmd.dec_load) begin
         dec_in = prod_ff;
      end
      if (cmd.dec_add4) begin
         dec_in = dec_ff + (prod_ff <<< 2);
      end
      if (cmd.dec_sub4) begin
         dec_in   = dec_ff - (prod_ff <<< 2);
         in_r2_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff   <= '0;
         off_y_ff   <= '0;
         slope_x_ff <= '0;
         slope_y_ff <= '0;
         dec_ff     <= '0;
         in_r2_ff   <= 1'b0;
         active_ff  <= 1'b0;
         simple_ff  <= 1'b0;
      end else begin
         off_x_ff   <= off_x_in;
         off_y_ff   <= off_y_in;
         slope_x_ff <= slope_x_in;
         slope_y_ff <= slope_y_in;
         dec_ff     <= dec_in;
         in_r2_ff   <= in_r2_in;
         active_ff  <= active_in;
         simple_ff  <= simple_in;
      end
   end

   // Four mirrored points, wrapped to the coordinate width.
   assign cx_c = COORD_BITS'(signed'({1'b0, center_x_ff}));
   assign cy_c = COORD_BITS'(signed'({1'b0, center_y_ff}));
   assign ox_c = COORD_BITS'(off_x_ff);
   assign oy_c = COORD_BITS'(off_y_ff);

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= DATA_W'({cy_c - oy_c, cy_c + oy_c, cx_c - ox_c, cx_c + ox_c});
         rsp_last_ff <= last_pt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign sts.active   = active_ff;
   assign sts.in_r2    = in_r2_ff;
   assign sts.slope_lt = slope_x_ff < slope_y_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign sts.last_pt  = last_pt;

endmodule

>>> hdl/midpoint_ellipse_rasterizer_top.sv
// Channel   Direction  Ports                          Contents
// req       in         req_tvalid/tready/tdata[7:0]   restart in bit 0
// rsp       out        rsp_tvalid/tready/tdata/tlast  right_x, left_x, lower_y, upper_y
// csr       in         csr_we/index/wdata             centre x, centre y, radius x, radius y
//
// An advance request passes through the emit and update states; a restart first runs the init,
// init-finish and init-test states. Entering region two runs the states E_TT to E_FIN, with the shared
// multiplier working through the five products of the region-two start value one per cycle.
// Reset is synchronous; afterwards the block is idle until a restart request.
// A waiting result holds the sequencer in its emit state until it is taken.
module midpoint_ellipse_rasterizer_top #(
   parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
   localparam int CSR_W  = (RADIUS_BITS > mer_pkg::CENTER_BITS) ?
                           RADIUS_BITS : mer_pkg::CENTER_BITS,
   localparam int DATA_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // restart
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [DATA_W-1:0]                  rsp_tdata,   // right_x, left_x, lower_y, upper_y
   output logic                               rsp_tlast,   // last_step
   // Configuration port.
   input  logic                               csr_we,
   input  logic [mer_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_W-1:0]                   csr_wdata
);
   import mer_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   mer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_restart (req_tdata[0]),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Arithmetic, walk state, configuration and result registers.
   mer_datapath #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // A result is only loaded when the output register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded over an untaken result");

   // The final points of an ellipse stop the walk.
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.last_pt) |=> !sts.active)
      else $error("walk still active after its last points");

   // Finishing the start value always leaves the walk in region two.
   a_enter_r2: assert property (@(posedge clock) disable iff (reset)
      cmd.dec_sub4 |=> sts.in_r2)
      else $error("region two not entered");

   // A restart makes the walk active.
   a_init_active: assert property (@(posedge clock) disable iff (reset)
      cmd.init |=> sts.active)
      else $error("restart did not activate the walk");
`endif

endmodule
